/* design/lre_pkg.sv */
package lre_pkg;

  // exponent register width and register defaults
  localparam int unsigned EXP_BITS          = 14;
  localparam int unsigned MODULUS_BITS_DEF  = 14;
  localparam int unsigned EXP_RESET         = 3;
  localparam int unsigned MODULUS_RESET     = 9409;

  // configuration register indices
  localparam logic [0:0] REG_PUBLIC_EXPONENT = 1'b0;
  localparam logic [0:0] REG_RSA_MODULUS     = 1'b1;

  // character constants
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_K       = 8'h4B;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_Z_LOWER = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // microprogram
  localparam int unsigned PC_W = 3;

  localparam logic [PC_W-1:0] S_INIT   = 3'd0;
  localparam logic [PC_W-1:0] S_BASE   = 3'd1;
  localparam logic [PC_W-1:0] S_SQUARE = 3'd2;
  localparam logic [PC_W-1:0] S_TEST   = 3'd3;
  localparam logic [PC_W-1:0] S_MULB   = 3'd4;
  localparam logic [PC_W-1:0] S_LOOP   = 3'd5;
  localparam logic [PC_W-1:0] S_DONE   = 3'd6;

  typedef enum logic [2:0] {
    U_INIT,
    U_MUL,
    U_TEST,
    U_LOOP,
    U_DONE
  } uop_e;

  typedef enum logic [1:0] {
    M_BASE,
    M_SQR,
    M_MULB
  } mul_sel_e;

  typedef struct packed {
    uop_e            op;
    mul_sel_e        sel;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: U_DONE, sel: M_SQR, target: S_DONE};
    case (pc)
      S_INIT:   w = '{op: U_INIT, sel: M_SQR,  target: S_DONE};
      S_BASE:   w = '{op: U_MUL,  sel: M_BASE, target: S_SQUARE};
      S_SQUARE: w = '{op: U_MUL,  sel: M_SQR,  target: S_TEST};
      S_TEST:   w = '{op: U_TEST, sel: M_SQR,  target: S_LOOP};
      S_MULB:   w = '{op: U_MUL,  sel: M_MULB, target: S_LOOP};
      S_LOOP:   w = '{op: U_LOOP, sel: M_SQR,  target: S_SQUARE};
      S_DONE:   w = '{op: U_DONE, sel: M_SQR,  target: S_DONE};
      default:  w = '{op: U_DONE, sel: M_SQR,  target: S_DONE};
    endcase
    return w;
  endfunction

  // letter to code on the alphabet without k, w and y; 0 when it does not map
  function automatic logic [4:0] letter_code(input logic [7:0] ch);
    logic [7:0] c;
    logic [7:0] r;
    c = ch;
    r = 8'd0;
    if (c inside {[CH_A_LOWER:CH_Z_LOWER]}) c = c - CASE_GAP;
    if (c >= CH_A && c < CH_K)      r = c - CH_A + 8'd1;
    else if (c > CH_K && c < CH_W)  r = c - CH_A;
    else if (c == CH_X)             r = c - CH_A - 8'd1;
    else if (c == CH_Z)             r = c - CH_A - 8'd2;
    return r[4:0];
  endfunction

endpackage

/* design/letter_rsa_encryptor.sv */
// letter rsa encryptor: one character in, one ciphertext item out. pulse start
// while busy is low; busy then stays high until the item is done, and the
// result is shown for exactly one cycle with done_o high. the receiver cannot
// stall, so it must take the result in that cycle. letters are folded to upper
// case and coded 1-23 (k, w and y dropped); the result is code^e mod n by
// left-to-right square-and-multiply over all 14 exponent bits. every modular
// product runs on one bit-serial shift-add-reduce unit, one multiplier bit
// per cycle. a non-letter, k, w, y or a modulus of zero skips the products
// and gives zeros in cipher_value (a modulus of zero still reports the letter
// code). the exponent and modulus registers must only be written while busy
// is low.
module letter_rsa_encryptor
  import lre_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [7:0]              character_i,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [((MODULUS_BITS > EXP_BITS) ? MODULUS_BITS : EXP_BITS)-1:0] cfg_data_i,
  output logic                    done_o,
  output logic [MODULUS_BITS-1:0] cipher_value_o,
  output logic [4:0]              letter_code_o,
  output logic                    is_valid_o
);

  localparam int unsigned MB   = MODULUS_BITS;
  localparam int unsigned CntW = $clog2(MB);
  localparam int unsigned EbW  = $clog2(EXP_BITS);

  // control state
  logic                busy_q, busy_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic                mul_busy_q, mul_busy_d;
  logic                done_q, done_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [MB-1:0]       mod_q, mod_d;

  // datapath
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [MB-1:0]       r_q, r_d;
  logic [MB-1:0]       acc_q, acc_d;
  logic [MB-1:0]       b_q, b_d;
  logic [EbW-1:0]      ebit_q, ebit_d;
  logic [4:0]          code_q, code_d;
  logic                valid_q, valid_d;
  logic [MB-1:0]       cipher_q, cipher_d;
  logic [4:0]          code_out_q, code_out_d;
  logic                valid_out_q, valid_out_d;

  ucode_t              uc;
  logic [MB-1:0]       one_n;
  logic [MB-1:0]       scan;
  logic [MB-1:0]       mcand;
  logic [CntW-1:0]     idx;
  logic [MB-1:0]       r_in;
  logic [MB+1:0]       t;
  logic [MB+1:0]       n1;
  logic [MB+1:0]       n2;
  logic [MB+1:0]       t_sub1;
  logic [MB+1:0]       t_sub2;
  logic [MB-1:0]       r_next;
  logic                mul_last;
  logic [4:0]          code_in;

  assign uc      = ucode_rom(pc_q);
  assign one_n   = (mod_q == MB'(1)) ? '0 : MB'(1);
  assign code_in = letter_code(character_i);

  // operand routing for the serial multiplier
  always_comb begin
    case (uc.sel)
      M_BASE: begin
        scan  = {{(MB-5){1'b0}}, code_q};
        mcand = one_n;
      end
      M_SQR: begin
        scan  = acc_q;
        mcand = acc_q;
      end
      M_MULB: begin
        scan  = acc_q;
        mcand = b_q;
      end
      default: begin
        scan  = acc_q;
        mcand = acc_q;
      end
    endcase
  end

  // one step of r = 2r + bit*mcand mod n, msb first; r and mcand stay below n
  assign idx      = mul_busy_q ? cnt_q : CntW'(MB - 1);
  assign r_in     = mul_busy_q ? r_q : '0;
  assign t        = {1'b0, r_in, 1'b0} + (scan[idx] ? {2'b00, mcand} : '0);
  assign n1       = {2'b00, mod_q};
  assign n2       = {1'b0, mod_q, 1'b0};
  assign t_sub1   = t - n1;
  assign t_sub2   = t - n2;
  assign r_next   = (t >= n2) ? t_sub2[MB-1:0] :
                    (t >= n1) ? t_sub1[MB-1:0] : t[MB-1:0];
  assign mul_last = (idx == '0);

  // sequencer
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    mul_busy_d  = mul_busy_q;
    done_d      = 1'b0;
    exp_d       = exp_q;
    mod_d       = mod_q;
    cnt_d       = cnt_q;
    r_d         = r_q;
    acc_d       = acc_q;
    b_d         = b_q;
    ebit_d      = ebit_q;
    code_d      = code_q;
    valid_d     = valid_q;
    cipher_d    = cipher_q;
    code_out_d  = code_out_q;
    valid_out_d = valid_out_q;

    if (!busy_q) begin
      if (start) begin
        busy_d  = 1'b1;
        pc_d    = S_INIT;
        code_d  = code_in;
        valid_d = (code_in != 5'd0);
      end
    end else begin
      case (uc.op)
        U_INIT: begin
          acc_d  = one_n;
          ebit_d = EbW'(EXP_BITS - 1);
          // nothing to compute for a non-letter or a zero modulus
          if (!valid_q || mod_q == '0) pc_d = uc.target;
          else                         pc_d = pc_q + PC_W'(1);
        end
        U_MUL: begin
          mul_busy_d = 1'b1;
          r_d        = r_next;
          cnt_d      = idx - CntW'(1);
          if (mul_last) begin
            mul_busy_d = 1'b0;
            pc_d       = pc_q + PC_W'(1);
            if (uc.sel == M_BASE) b_d   = r_next;
            else                  acc_d = r_next;
          end
        end
        U_TEST: begin
          // multiply step only where the exponent bit is set
          if (exp_q[ebit_q]) pc_d = pc_q + PC_W'(1);
          else               pc_d = uc.target;
        end
        U_LOOP: begin
          if (ebit_q == '0) begin
            pc_d = pc_q + PC_W'(1);
          end else begin
            ebit_d = ebit_q - EbW'(1);
            pc_d   = uc.target;
          end
        end
        U_DONE: begin
          busy_d      = 1'b0;
          done_d      = 1'b1;
          cipher_d    = (valid_q && mod_q != '0) ? acc_q : '0;
          code_out_d  = code_q;
          valid_out_d = valid_q;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PUBLIC_EXPONENT: exp_d = cfg_data_i[EXP_BITS-1:0];
        REG_RSA_MODULUS:     mod_d = cfg_data_i[MB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pc_q       <= S_INIT;
      mul_busy_q <= 1'b0;
      done_q     <= 1'b0;
      exp_q      <= EXP_BITS'(EXP_RESET);
      mod_q      <= MB'(MODULUS_RESET);
    end else begin
      busy_q     <= busy_d;
      pc_q       <= pc_d;
      mul_busy_q <= mul_busy_d;
      done_q     <= done_d;
      exp_q      <= exp_d;
      mod_q      <= mod_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    r_q         <= r_d;
    acc_q       <= acc_d;
    b_q         <= b_d;
    ebit_q      <= ebit_d;
    code_q      <= code_d;
    valid_q     <= valid_d;
    cipher_q    <= cipher_d;
    code_out_q  <= code_out_d;
    valid_out_q <= valid_out_d;
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign cipher_value_o = cipher_q;
  assign letter_code_o  = code_out_q;
  assign is_valid_o     = valid_out_q;

  // the result strobe lands as the block frees up
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while still busy");

  // results are never back to back: every item needs at least two steps
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // a rejected character reports all zeros
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_valid_o) |-> (cipher_value_o == '0 && letter_code_o == 5'd0))
    else $error("invalid item with non-zero payload");

  // the serial multiplier only runs inside an item
  a_mul_in_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_busy_q |-> busy_q) else $error("multiplier active while idle");

endmodule

/* tb/tb_letter_rsa_encryptor.sv */
`timescale 1ns / 100ps

module tb_letter_rsa_encryptor;
  import lre_pkg::*;

  localparam int unsigned MW = MODULUS_BITS_DEF;
  localparam int unsigned CW = (MW > EXP_BITS) ? MW : EXP_BITS;

  // no cycle without an accepted item or a result may last this long: the limit
  // covers the slowest item (all 14 exponent bits set), the longest sender gap
  // and a key change
  localparam int unsigned STALL_LIMIT = 5000;
  // quiet cycles after the last result, above the slowest item
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam int unsigned ITEMS_PER_KEY = 100;
  localparam int unsigned NUM_KEYS = 17;

  // one result item as the block reports it
  typedef struct packed {
    logic [MW-1:0] cipher;
    logic [4:0]    code;
    logic          valid;
  } cipher_res_t;

  // directed row: the character, and the result typed in where it is obvious
  typedef struct packed {
    logic [7:0]  ch;
    bit          typed;
    cipher_res_t res;
  } dir_row_t;

  // directed rows, sent under the reset key (e = 3, n = 9409)
  localparam dir_row_t DIR_ROWS [22] = '{
    '{8'h00, 1'b1, '{14'd0,    5'd0,  1'b0}},  // lowest byte
    '{8'hFF, 1'b1, '{14'd0,    5'd0,  1'b0}},  // highest byte
    '{8'h80, 1'b1, '{14'd0,    5'd0,  1'b0}},  // top half of the byte range
    '{8'h41, 1'b1, '{14'd1,    5'd1,  1'b1}},  // first letter, 1^3
    '{8'h61, 1'b1, '{14'd1,    5'd1,  1'b1}},  // same in lower case
    '{8'h42, 1'b1, '{14'd8,    5'd2,  1'b1}},
    '{8'h4A, 1'b1, '{14'd1000, 5'd10, 1'b1}},  // last letter before the k gap
    '{8'h6A, 1'b1, '{14'd1000, 5'd10, 1'b1}},
    '{8'h4B, 1'b1, '{14'd0,    5'd0,  1'b0}},  // dropped letters, both cases
    '{8'h6B, 1'b1, '{14'd0,    5'd0,  1'b0}},
    '{8'h57, 1'b1, '{14'd0,    5'd0,  1'b0}},
    '{8'h79, 1'b1, '{14'd0,    5'd0,  1'b0}},
    '{8'h4C, 1'b1, '{14'd1331, 5'd11, 1'b1}},  // first letter after the k gap
    '{8'h40, 1'b1, '{14'd0,    5'd0,  1'b0}},  // neighbours of both letter ranges
    '{8'h5B, 1'b1, '{14'd0,    5'd0,  1'b0}},
    '{8'h60, 1'b1, '{14'd0,    5'd0,  1'b0}},
    '{8'h7B, 1'b1, '{14'd0,    5'd0,  1'b0}},
    '{8'h56, 1'b0, '{14'd0,    5'd0,  1'b0}},  // rest through the predictor
    '{8'h58, 1'b0, '{14'd0,    5'd0,  1'b0}},
    '{8'h5A, 1'b0, '{14'd0,    5'd0,  1'b0}},  // code 23, cube wraps the modulus
    '{8'h7A, 1'b0, '{14'd0,    5'd0,  1'b0}},
    '{8'h6D, 1'b0, '{14'd0,    5'd0,  1'b0}}
  };

  // fixed keys first: exponent zero, the extremes, modulus two, one and zero
  localparam int unsigned NUM_FIXED_KEYS = 9;
  localparam logic [CW-1:0] FIXED_E [NUM_FIXED_KEYS] = '{
    14'd0, 14'd16383, 14'd1, 14'd9408, 14'd5, 14'd7, 14'd0, 14'd17, 14'd16383
  };
  localparam logic [CW-1:0] FIXED_N [NUM_FIXED_KEYS] = '{
    14'd9409, 14'd16383, 14'd2, 14'd9409, 14'd1, 14'd0, 14'd0, 14'd3233, 14'd1
  };

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic [7:0]    character_i;
  logic          cfg_we_i;
  logic [0:0]    cfg_idx_i;
  logic [CW-1:0] cfg_data_i;
  logic          done_o;
  logic [MW-1:0] cipher_value_o;
  logic [4:0]    letter_code_o;
  logic          is_valid_o;

  // our copy of the key registers, updated at the write edge
  logic [EXP_BITS-1:0] key_e;
  logic [MW-1:0]       key_n;

  // ciphertexts still owed by the block, oldest first
  cipher_res_t cipher_q [$];
  cipher_res_t got_res;

  int unsigned err_cnt;
  int unsigned stall_cnt;
  int unsigned sent_cnt;
  int unsigned letter_cnt;
  int unsigned idle_pct;

  letter_rsa_encryptor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .character_i    (character_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .cipher_value_o (cipher_value_o),
    .letter_code_o  (letter_code_o),
    .is_valid_o     (is_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // position on the 23-letter alphabet: index from 'A' plus one, less one
  // for every dropped letter (k, w, y) that lies below it
  function automatic logic [4:0] alpha_code(input logic [7:0] ch);
    logic [7:0] up;
    logic [7:0] skipped;
    up = ch;
    skipped = 8'd0;
    if (ch >= CH_A_LOWER && ch <= CH_Z_LOWER) up = ch - CASE_GAP;
    if (up < CH_A || up > CH_Z || up == CH_K || up == CH_W || up == CH_Y) return 5'd0;
    if (up > CH_K) skipped = skipped + 8'd1;
    if (up > CH_W) skipped = skipped + 8'd1;
    if (up > CH_Y) skipped = skipped + 8'd1;
    return 5'(up - CH_A + 8'd1 - skipped);
  endfunction

  // code^e mod n, msb-first square-and-multiply over every exponent bit;
  // a zero modulus has no residue and gives zero
  function automatic logic [MW-1:0] rsa_power(input logic [4:0] code,
                                               input logic [EXP_BITS-1:0] e,
                                               input logic [MW-1:0] n);
    logic [2*MW-1:0] acc;
    logic [2*MW-1:0] b;
    int i;
    if (n == '0) return '0;
    acc = (2*MW)'(1) % n;
    b = (2*MW)'(code) % n;
    for (i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % n;
      if (e[i]) acc = (acc * b) % n;
    end
    return acc[MW-1:0];
  endfunction

  // result of one character under the current key
  function automatic cipher_res_t encrypt_char(input logic [7:0] ch);
    cipher_res_t r;
    r.code = alpha_code(ch);
    r.valid = (r.code != 5'd0);
    r.cipher = r.valid ? rsa_power(r.code, key_e, key_n) : '0;
    return r;
  endfunction

  // offer one item after a random gap; start is left high after acceptance,
  // so back-to-back items never drop it within one step
  task automatic send_char(input logic [7:0] ch, input bit use_typed,
                           input cipher_res_t typed_res);
    int unsigned gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    character_i <= ch;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // taken at this edge
    cipher_q.push_back(use_typed ? typed_res : encrypt_char(ch));
    sent_cnt++;
    if (alpha_code(ch) != 5'd0) letter_cnt++;
  endtask

  // keys only change with the block idle and nothing outstanding
  task automatic load_key(input logic [CW-1:0] e, input logic [CW-1:0] n);
    start <= 1'b0;
    while (cipher_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_PUBLIC_EXPONENT;
    cfg_data_i <= e;
    @(posedge clk_i);
    key_e = e[EXP_BITS-1:0];
    cfg_idx_i <= REG_RSA_MODULUS;
    cfg_data_i <= n;
    @(posedge clk_i);
    key_n = n[MW-1:0];
    cfg_we_i <= 1'b0;
  endtask

  // mostly letters in either case, the rest any byte at all
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return ((r % 2) ? CH_A_LOWER : CH_A) + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // every result is compared with the oldest outstanding ciphertext
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (cipher_q.size() == 0) begin
        $error("result with nothing outstanding: cipher_value %0d letter_code %0d",
               cipher_value_o, letter_code_o);
        err_cnt++;
      end else begin
        got_res = cipher_q.pop_front();
        if (cipher_value_o !== got_res.cipher) begin
          $error("cipher_value: expected %0d, got %0d", got_res.cipher, cipher_value_o);
          err_cnt++;
        end
        if (letter_code_o !== got_res.code) begin
          $error("letter_code: expected %0d, got %0d", got_res.code, letter_code_o);
          err_cnt++;
        end
        if (is_valid_o !== got_res.valid) begin
          $error("is_valid: expected %0d, got %0d", got_res.valid, is_valid_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too long without an accepted item or a result ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d results outstanding",
               stall_cnt, cipher_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int unsigned k;
    int unsigned j;
    logic [CW-1:0] e;
    logic [CW-1:0] n;
    err_cnt = 0;
    sent_cnt = 0;
    letter_cnt = 0;
    idle_pct = 22;
    key_e = EXP_BITS'(EXP_RESET);
    key_n = MW'(MODULUS_RESET);
    rst_ni <= 1'b0;
    start <= 1'b0;
    character_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_PUBLIC_EXPONENT;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset key
    for (j = 0; j < $size(DIR_ROWS); j++) begin
      send_char(DIR_ROWS[j].ch, DIR_ROWS[j].typed, DIR_ROWS[j].res);
    end

    // random part, one batch per key; sender idling is moderate, then heavy, then off
    for (k = 0; k < NUM_KEYS; k++) begin
      if (k < 6) idle_pct = 22;
      else if (k < 12) idle_pct = 86;
      else idle_pct = 0;
      if (k < NUM_FIXED_KEYS) begin
        e = FIXED_E[k];
        n = FIXED_N[k];
      end else begin
        e = CW'($urandom_range(16383));
        // mostly moduli in the usual key range, sometimes anywhere
        n = ($urandom_range(3) == 0) ? CW'($urandom_range(16383))
                                     : CW'($urandom_range(9409, 2));
      end
      load_key(e, n);
      for (j = 0; j < ITEMS_PER_KEY; j++) begin
        send_char(pick_char(), 1'b0, '0);
      end
    end

    // drain, then stay quiet long enough to catch a stray result
    start <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d characters sent, %0d of them mapped letters, %0d rejected",
             sent_cnt, letter_cnt, sent_cnt - letter_cnt);
    $display("keys: reset plus %0d more, exponent and modulus down to 0 and up to 16383",
             NUM_KEYS);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
